>>> src/bdq_pkg.sv
// Shared types, codes and constants of the bounded double-ended queue.
package bdq_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int OP_W    = 3;
  localparam int FIELD_W = 32;
  localparam int CAP_W   = 11;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_STORE_DEPTH = 1024;
  localparam int DEFAULT_WORD_WIDTH  = 32;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Operation codes; the unused codes behave as a query.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic read;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> src/bdq_in_if.sv
// Input channel of the queue: one operation item per handshake.
interface bdq_in_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::OP_W-1:0]          operation;
  logic signed [bdq_pkg::FIELD_W-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

>>> src/bdq_out_if.sv
// Result channel of the queue: one result item per operation.
interface bdq_out_if;
  logic                               valid;
  logic                               ready;
  logic                               success;
  logic signed [bdq_pkg::FIELD_W-1:0] front_value;
  logic signed [bdq_pkg::FIELD_W-1:0] rear_value;
  logic                               is_empty;
  logic                               is_full;

  modport source (output valid, output success, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input success, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

>>> src/bdq_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdq_pkg::dp_status_t status,
  output bdq_pkg::dp_cmd_t    cmd
);

  bdq_pkg::state_t state_r;
  bdq_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: accept, update, read the ends, then hand over the result.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = bdq_pkg::ST_EXEC;
      end
      bdq_pkg::ST_EXEC: begin
        state_nxt = bdq_pkg::ST_READ;
      end
      bdq_pkg::ST_READ: begin
        state_nxt = bdq_pkg::ST_RESP;
      end
      bdq_pkg::ST_RESP: begin
        if (status.out_free) state_nxt = bdq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      bdq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      bdq_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      bdq_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      bdq_pkg::ST_RESP: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> src/bdq_dp.sv
// Datapath of the queue: ring storage, end pointers, count and result register.
module bdq_dp #(
  parameter int STORE_DEPTH = bdq_pkg::DEFAULT_STORE_DEPTH,
  parameter int WORD_WIDTH  = bdq_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]          cfg_data,
  input  logic [bdq_pkg::OP_W-1:0]           in_operation,
  input  logic signed [bdq_pkg::FIELD_W-1:0] in_push_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_success,
  output logic signed [bdq_pkg::FIELD_W-1:0] out_front_value,
  output logic signed [bdq_pkg::FIELD_W-1:0] out_rear_value,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  input  bdq_pkg::dp_cmd_t                   cmd,
  output bdq_pkg::dp_status_t                status
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;
  localparam logic [AW-1:0]    LAST_SLOT = AW'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    next_slot = (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
    prev_slot = (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  logic signed [WORD_WIDTH-1:0] mem [STORE_DEPTH];

  logic [bdq_pkg::CAP_W-1:0]    cap_r;
  logic [bdq_pkg::OP_W-1:0]     op_r;
  logic signed [WORD_WIDTH-1:0] val_r;
  logic [AW-1:0]                front_r, front_nxt;
  logic [AW-1:0]                back_r, back_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         ok_r, ok_nxt;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [WORD_WIDTH-1:0] rd_front_r, rd_rear_r;
  logic                         full, empty;
  logic                         out_valid_r;
  logic                         success_r, is_empty_r, is_full_r;
  logic signed [bdq_pkg::FIELD_W-1:0] front_value_r, rear_value_r;

  // Capacity register; a value above the storage depth acts as the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bdq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      val_r <= WORD_WIDTH'(in_push_value);
    end
  end

  // Occupancy flags from the current count.
  assign empty = (count_r == '0);
  assign full  = (CMP_W'(count_r) >= CMP_W'(cap_r)) || (count_r >= DEPTH_CNT);

  // Pointer and count update for the latched operation.
  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    ok_nxt    = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = back_r;
    case (op_r)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          front_nxt = prev_slot(front_r);
          wr_en     = 1'b1;
          wr_addr   = prev_slot(front_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = back_r;
          back_nxt  = next_slot(back_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          ok_nxt = 1'b0;
        end else begin
          front_nxt = next_slot(front_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          ok_nxt = 1'b0;
        end else begin
          back_nxt  = prev_slot(back_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        ok_nxt = 1'b1;
      end
    endcase
  end

  // Queue state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r <= ok_nxt;
    end
  end

  // Ring storage: one write in the update cycle, both ends read in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.read) begin
      rd_front_r <= mem[front_r];
      rd_rear_r  <= mem[prev_slot(back_r)];
    end
  end

  // Result register; it holds the item until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      success_r     <= ok_r;
      is_empty_r    <= empty;
      is_full_r     <= full;
      front_value_r <= empty ? '1 : bdq_pkg::FIELD_W'(rd_front_r);
      rear_value_r  <= empty ? '1 : bdq_pkg::FIELD_W'(rd_rear_r);
    end
  end

  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_success     = success_r;
  assign out_front_value = front_value_r;
  assign out_rear_value  = rear_value_r;
  assign out_is_empty    = is_empty_r;
  assign out_is_full     = is_full_r;

endmodule

>>> src/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: controller and datapath.
//
//   Channel   Direction  Handshake      Payload
//   in_ch     sink       valid/ready    operation, push_value
//   out_ch    source     valid/ready    success, front_value, rear_value, is_empty, is_full
//   cfg_*     input      write enable   capacity
//
// After its item is accepted, the result goes through the pointer update with the storage
// write, the registered read of both ends and the result load. The input reopens in the cycle
// after the load, so no new item is taken before the last one's result has been loaded.
// The single ring memory is written and then read for each item.
// Reset is synchronous and active low; it empties the queue and sets capacity to 1024.
// The result register frees the input side: a new item is accepted while a result waits,
// but its own result is held back until the previous one has been taken.
module bounded_double_ended_queue #(
  parameter int STORE_DEPTH = bdq_pkg::DEFAULT_STORE_DEPTH,
  parameter int WORD_WIDTH  = bdq_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bdq_in_if.sink                    in_ch,
  bdq_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_data
);

  bdq_pkg::dp_cmd_t    cmd;
  bdq_pkg::dp_status_t status;

  // Sequencing of each item.
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, pointers and result register.
  bdq_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_operation    (in_ch.operation),
    .in_push_value   (in_ch.push_value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_success     (out_ch.success),
    .out_front_value (out_ch.front_value),
    .out_rear_value  (out_ch.rear_value),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full),
    .cmd             (cmd),
    .status          (status)
  );

  // Only one item is in flight: after acceptance the input closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted again while an item is in flight");

  // A result appears only when the controller loads it.
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result valid without a load command");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten while still held");

  // Loading the result always leaves it presented in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_ch.valid)
    else $error("loaded result not presented");

endmodule

>>> bench/bounded_double_ended_queue_tb.sv
// Testbench of the bounded double-ended queue: a directed table, then random capacity phases.
`timescale 1ns / 100ps

module bounded_double_ended_queue_tb;

  localparam int DEPTH       = bdq_pkg::DEFAULT_STORE_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  localparam logic [bdq_pkg::FIELD_W-1:0] EMPTY_WORD = '1;
  localparam logic [bdq_pkg::FIELD_W-1:0] WORD_MAX   = 32'h7FFF_FFFF;
  localparam logic [bdq_pkg::FIELD_W-1:0] WORD_MIN   = 32'h8000_0000;

  // Spare operation codes; the block treats them as a query.
  localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic                        success;
    logic [bdq_pkg::FIELD_W-1:0] front_value;
    logic [bdq_pkg::FIELD_W-1:0] rear_value;
    logic                        is_empty;
    logic                        is_full;
  } deque_result_t;

  typedef enum bit {ROW_ITEM, ROW_CAPACITY} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [bdq_pkg::OP_W-1:0]    op;
    logic [bdq_pkg::FIELD_W-1:0] value;
    bit                          typed;
    deque_result_t               want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [bdq_pkg::CAP_W-1:0] cfg_data;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  // Predictor state: ring contents, end slots, fill level and capacity.
  logic [bdq_pkg::FIELD_W-1:0] ring_words [DEPTH];
  int                          head_slot;
  int                          tail_slot;
  int                          held_count;
  logic [bdq_pkg::CAP_W-1:0]   capacity_reg;

  deque_result_t expected_results [$];
  stim_row_t     directed_rows [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;

  bounded_double_ended_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Free-running clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** bounded_double_ended_queue: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [bdq_pkg::FIELD_W-1:0] got,
                               input logic [bdq_pkg::FIELD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Applies one operation to the predictor and works out the result it gives.
  task automatic predict_operation(input logic [bdq_pkg::OP_W-1:0] op,
                                   input logic [bdq_pkg::FIELD_W-1:0] val,
                                   output deque_result_t res);
    int limit;
    bit full;
    bit ok;
    limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
    full  = held_count >= limit;
    ok    = 1'b1;
    case (op)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          ok = 1'b0;
        end else begin
          head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
          ring_words[head_slot] = val;
          held_count++;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          ok = 1'b0;
        end else begin
          ring_words[tail_slot] = val;
          tail_slot = (tail_slot == DEPTH - 1) ? 0 : tail_slot + 1;
          held_count++;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (held_count == 0) begin
          ok = 1'b0;
        end else begin
          head_slot = (head_slot == DEPTH - 1) ? 0 : head_slot + 1;
          held_count--;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (held_count == 0) begin
          ok = 1'b0;
        end else begin
          tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
          held_count--;
        end
      end
      default: begin
      end
    endcase
    res.success = ok;
    if (held_count == 0) begin
      res.front_value = EMPTY_WORD;
      res.rear_value  = EMPTY_WORD;
      res.is_empty    = 1'b1;
    end else begin
      res.front_value = ring_words[head_slot];
      res.rear_value  = ring_words[(tail_slot == 0) ? DEPTH - 1 : tail_slot - 1];
      res.is_empty    = 1'b0;
    end
    res.is_full = held_count >= limit;
  endtask

  // Each accepted result item is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with no operation outstanding");
      end else begin
        want = expected_results.pop_front();
        compare_field("success", bdq_pkg::FIELD_W'(out_ch.success),
                      bdq_pkg::FIELD_W'(want.success));
        compare_field("front_value", out_ch.front_value, want.front_value);
        compare_field("rear_value", out_ch.rear_value, want.rear_value);
        compare_field("is_empty", bdq_pkg::FIELD_W'(out_ch.is_empty),
                      bdq_pkg::FIELD_W'(want.is_empty));
        compare_field("is_full", bdq_pkg::FIELD_W'(out_ch.is_full),
                      bdq_pkg::FIELD_W'(want.is_full));
      end
    end
  end

  // Random bursts of back-pressure on the result side.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (!calm && rst_n && $urandom_range(0, 99) < idle_pct) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offers one item and records its expectation once accepted. Valid is left high
  // so that a following item can go out back to back.
  task automatic send_item(input logic [bdq_pkg::OP_W-1:0] op,
                           input logic [bdq_pkg::FIELD_W-1:0] val,
                           input bit typed, input deque_result_t want);
    deque_result_t predicted;
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.push_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    predict_operation(op, val, predicted);
    expected_results.push_back(typed ? want : predicted);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every outstanding result drain so that the block is idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity_reg = value;
  endtask

  function automatic void add_row(input row_kind_t kind, input logic [bdq_pkg::OP_W-1:0] op,
                                  input logic [bdq_pkg::FIELD_W-1:0] value, input bit typed,
                                  input logic s, input logic [bdq_pkg::FIELD_W-1:0] f,
                                  input logic [bdq_pkg::FIELD_W-1:0] r, input logic e,
                                  input logic fu);
    stim_row_t row;
    row.kind  = kind;
    row.op    = op;
    row.value = value;
    row.typed = typed;
    row.want  = '{success: s, front_value: f, rear_value: r, is_empty: e, is_full: fu};
    directed_rows.push_back(row);
  endfunction

  // One random phase at a given capacity. With swing set, the push share flips
  // every sixteen items so the queue travels between empty and full.
  task automatic run_phase(input logic [bdq_pkg::CAP_W-1:0] cap, input int count,
                           input int push_pct, input bit swing, input int idle);
    int i;
    int r;
    int pct;
    logic [bdq_pkg::OP_W-1:0]    op;
    logic [bdq_pkg::FIELD_W-1:0] val;
    write_capacity(cap);
    idle_pct = idle;
    for (i = 0; i < count; i++) begin
      pct = (swing && ((i / 16) % 2 == 1)) ? 100 - push_pct : push_pct;
      r   = $urandom_range(0, 99);
      if (r < pct) begin
        op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
      end else if (r < 95) begin
        op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
      end else begin
        op = bdq_pkg::OP_W'($urandom_range(bdq_pkg::OP_QUERY, OP_SPARE_7));
      end
      case ($urandom_range(0, 9))
        0:       val = WORD_MAX;
        1:       val = WORD_MIN;
        2:       val = EMPTY_WORD;
        3:       val = '0;
        default: val = $urandom;
      endcase
      send_item(op, val, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    stim_row_t row;
    in_ch.valid      = 1'b0;
    in_ch.operation  = bdq_pkg::OP_QUERY;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = bdq_pkg::CAP_RESET;
    rst_n            = 1'b0;
    head_slot        = 0;
    tail_slot        = 0;
    held_count       = 0;
    capacity_reg     = bdq_pkg::CAP_RESET;

    // Directed table: empty-queue refusals, extreme words, spare codes, a full
    // queue, capacity lowered below the fill level, capacity zero and saturation.
    add_row(ROW_ITEM, bdq_pkg::OP_QUERY, '0, 1'b1,
            1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_POP_FRONT, WORD_MAX, 1'b1,
            1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_POP_BACK, WORD_MIN, 1'b1,
            1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_FRONT, WORD_MAX, 1'b1,
            1'b1, WORD_MAX, WORD_MAX, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_BACK, WORD_MIN, 1'b1,
            1'b1, WORD_MAX, WORD_MIN, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_SPARE_5, '0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_SPARE_6, 32'h5A5A_A5A5, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_SPARE_7, EMPTY_WORD, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_CAPACITY, bdq_pkg::OP_QUERY, 32'd2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_FRONT, '0, 1'b1,
            1'b0, WORD_MAX, WORD_MIN, 1'b0, 1'b1);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_BACK, EMPTY_WORD, 1'b1,
            1'b0, WORD_MAX, WORD_MIN, 1'b0, 1'b1);
    add_row(ROW_CAPACITY, bdq_pkg::OP_QUERY, 32'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_QUERY, '0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_POP_FRONT, '0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_BACK, 32'h0000_0001, 1'b0,
            1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_POP_BACK, '0, 1'b1,
            1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0);
    add_row(ROW_CAPACITY, bdq_pkg::OP_QUERY, 32'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_FRONT, 32'd5, 1'b1,
            1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_BACK, 32'd6, 1'b1,
            1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1);
    add_row(ROW_ITEM, bdq_pkg::OP_QUERY, '0, 1'b1,
            1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1);
    add_row(ROW_CAPACITY, bdq_pkg::OP_QUERY, 32'd2047, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_BACK, 32'h1234_5678, 1'b0,
            1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0,
            1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_POP_BACK, '0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(ROW_ITEM, bdq_pkg::OP_POP_FRONT, '0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n    <= 1'b1;
    idle_pct = 30;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CAPACITY) begin
        write_capacity(row.value[bdq_pkg::CAP_W-1:0]);
      end else begin
        send_item(row.op, row.value, row.typed, row.want);
      end
    end

    // Random phases: small capacities swinging between empty and full, capacity
    // zero with entries held, a fill to a few hundred entries under a saturated
    // capacity, then pops with the capacity lowered far below the fill level.
    run_phase(11'd4, 120, 70, 1'b1, 30);
    run_phase(11'd1, 50, 50, 1'b0, 50);
    run_phase(11'd13, 120, 75, 1'b1, 0);
    run_phase(11'd0, 30, 40, 1'b0, 20);
    run_phase(11'd2047, 340, 92, 1'b0, 10);
    run_phase(11'd6, 120, 4, 1'b0, 10);
    run_phase(11'd3, 80, 60, 1'b1, 30);
    calm = 1'b1;
    run_phase(bdq_pkg::CAP_RESET, 120, 60, 1'b1, 0);

    // Let the last results out and watch for strays.
    drain_results();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatches == 0) begin
      $display("** bounded_double_ended_queue: PASSED **");
    end else begin
      $display("** bounded_double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule
